>>> rtl/core/hlda_pkg.sv
// Shared types, constants and constant tables for the half-life decay average.
`timescale 1ns / 1ps

package hlda_pkg;

    localparam int VALUE_FRAC_BITS  = 16;
    localparam int TABLE_INDEX_BITS = 6;
    localparam int TAB_SIZE         = 1 << TABLE_INDEX_BITS;
    localparam int FQ               = 30;
    localparam int LOG_FRAC         = 16;
    localparam int DIV_BITS         = 24 + 8 + TABLE_INDEX_BITS;
    localparam int HL_BITS          = 24;
    localparam int THR_BITS         = 31;
    localparam int TIME_BITS        = 32;
    localparam int VAL_BITS         = 32;
    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1) << VALUE_FRAC_BITS;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_PROJECT = 2'd1,
        ACT_RESET   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic {
        REG_HALF_LIFE = 1'b0,
        REG_THRESHOLD = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic load_in;
        logic div_init;
        logic div_step;
        logic fact;
        logic mul_lo;
        logic mul_hi;
        logic round;
        logic apply;
        logic norm_load;
        logic norm_step;
        logic log_calc;
        logic tmul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic norm_done;
        logic out_free;
    } t_sts;

    typedef logic [TAB_SIZE-1:0][FQ:0]         t_exp_tab;
    typedef logic [TAB_SIZE-1:0][LOG_FRAC-1:0] t_log_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bv;
        x   = v;
        res = 64'd0;
        bv  = 64'h4000_0000_0000_0000;
        while (bv > x) bv = bv >> 2;
        while (bv != 64'd0) begin
            if (x >= res + bv) begin
                x   = x - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    function automatic t_exp_tab build_exp_tab();
        logic [TABLE_INDEX_BITS-1:0][63:0] roots;
        logic [63:0] e;
        t_exp_tab tab;
        roots[TABLE_INDEX_BITS-1] = isqrt64(64'd1 << (2 * FQ - 1));
        for (int j = TABLE_INDEX_BITS - 1; j > 0; j--) begin
            roots[j-1] = isqrt64(roots[j] << FQ);
        end
        for (int i = 0; i < TAB_SIZE; i++) begin
            e = 64'd1 << FQ;
            for (int j = 0; j < TABLE_INDEX_BITS; j++) begin
                if (((i >> j) & 1) != 0) begin
                    e = (e * roots[j] + (64'd1 << (FQ - 1))) >> FQ;
                end
            end
            tab[i] = e[FQ:0];
        end
        return tab;
    endfunction

    function automatic t_log_tab build_log_tab();
        logic [63:0] y;
        logic [63:0] r;
        t_log_tab tab;
        for (int i = 0; i < TAB_SIZE; i++) begin
            y = (64'd1 << FQ) + (64'(i) << (FQ - TABLE_INDEX_BITS));
            r = 64'd0;
            for (int k = 0; k < LOG_FRAC; k++) begin
                y = (y * y) >> FQ;
                r = r << 1;
                if (y >= (64'd1 << (FQ + 1))) begin
                    r = r | 64'd1;
                    y = y >> 1;
                end
            end
            tab[i] = r[LOG_FRAC-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();
    localparam t_log_tab LOG_TAB = build_log_tab();

endpackage

>>> rtl/core/hlda_dp.sv
// Datapath: state, divider, multiplier, normalizer, log tables and result register.
`timescale 1ns / 1ps

module hlda_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hlda_pkg::t_cmd                      i_cmd,
    output hlda_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [hlda_pkg::THR_BITS-1:0]       i_cfg_wdata,
    input  logic [1:0]                          i_action,
    input  logic [hlda_pkg::VAL_BITS-1:0]       i_sample,
    input  logic [hlda_pkg::TIME_BITS-1:0]      i_timestamp,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [hlda_pkg::VAL_BITS-1:0]       o_current_value,
    output logic [hlda_pkg::VAL_BITS-1:0]       o_projected_value,
    output logic                                o_threshold_time_valid,
    output logic [hlda_pkg::TIME_BITS-1:0]      o_threshold_time
);
    localparam int TI = hlda_pkg::TABLE_INDEX_BITS;
    localparam int DB = hlda_pkg::DIV_BITS;
    localparam int HB = hlda_pkg::HL_BITS;
    localparam int FB = hlda_pkg::FQ + 1;
    localparam int LB = hlda_pkg::LOG_FRAC + 5;

    logic [HB-1:0]                     r_half_life;
    logic [hlda_pkg::THR_BITS-1:0]     r_threshold;
    logic signed [31:0]                r_avg;
    logic [31:0]                       r_last;
    logic                              r_has;
    hlda_pkg::t_action                 r_act;
    logic signed [31:0]                r_sample;
    logic [31:0]                       r_ts;
    logic [DB-1:0]                     r_dq;
    logic [HB-1:0]                     r_rem;
    logic [5:0]                        r_cnt;
    logic                              r_fzero;
    logic [FB-1:0]                     r_f;
    logic [32:0]                       r_mag;
    logic                              r_neg;
    logic [48:0]                       r_plo;
    logic [47:0]                       r_phi;
    logic signed [33:0]                r_prod;
    logic signed [31:0]                r_proj;
    logic [30:0]                       r_va;
    logic [30:0]                       r_vt;
    logic [4:0]                        r_pa;
    logic [4:0]                        r_pt;
    logic                              r_tvalid;
    logic [LB-1:0]                     r_d;
    logic [28:0]                       r_t;
    logic                              r_out_valid;
    logic [31:0]                       r_out_cur;
    logic [31:0]                       r_out_proj;
    logic                              r_out_tv;
    logic [31:0]                       r_out_t;

    logic [31:0]        n_elapsed;
    logic [HB:0]        n_trial;
    logic [HB:0]        n_rem_sh;
    logic               n_fbig;
    logic signed [32:0] n_opnd;
    logic [63:0]        n_sum;
    logic [33:0]        n_r;
    logic [30:0]        n_thr;
    logic [LB-1:0]      n_la;
    logic [LB-1:0]      n_lt;
    logic [44:0]        n_tprod;

    always_comb begin
        n_elapsed = (r_ts > r_last) ? r_ts - r_last : 32'd0;
        n_rem_sh  = {r_rem, r_dq[DB-1]};
        n_trial   = n_rem_sh - {1'b0, r_half_life};
        n_fbig    = (r_dq[DB-1:TI+5] != '0) || (r_dq[TI+4:TI] == 5'd31);
        n_opnd    = (r_act == hlda_pkg::ACT_UPDATE)
                  ? ({r_avg[31], r_avg} - {r_sample[31], r_sample})
                  : {r_avg[31], r_avg};
        n_sum     = {r_phi, 16'd0} + {15'd0, r_plo} + (64'd1 << (hlda_pkg::FQ - 1));
        n_r       = n_sum[63:30];
        n_thr     = (r_threshold == '0) ? 31'd1 : r_threshold;
        n_la      = {r_pa, hlda_pkg::LOG_TAB[r_va[29:30-TI]]};
        n_lt      = {r_pt, hlda_pkg::LOG_TAB[r_vt[29:30-TI]]};
        n_tprod   = r_half_life * r_d;
    end

    assign o_sts.div_last  = (r_cnt == 6'd0);
    assign o_sts.norm_done = (r_va[30] || r_pa == 5'd0) && (r_vt[30] || r_pt == 5'd0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_life <= '0;
            r_threshold <= hlda_pkg::THR_RESET;
            r_avg       <= '0;
            r_last      <= '0;
            r_has       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (hlda_pkg::t_reg_index'(i_cfg_index) == hlda_pkg::REG_HALF_LIFE) begin
                    r_half_life <= i_cfg_wdata[HB-1:0];
                end else begin
                    r_threshold <= i_cfg_wdata;
                end
            end
            if (i_cmd.apply) begin
                case (r_act)
                    hlda_pkg::ACT_UPDATE: begin
                        r_avg  <= r_has ? 32'(34'(r_sample) + r_prod) : r_sample;
                        r_last <= r_ts;
                        r_has  <= 1'b1;
                    end
                    hlda_pkg::ACT_RESET: begin
                        r_avg  <= '0;
                        r_last <= '0;
                        r_has  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act    <= hlda_pkg::t_action'(i_action);
            r_sample <= i_sample;
            r_ts     <= i_timestamp;
        end
        if (i_cmd.div_init) begin
            r_dq    <= {n_elapsed[23:0], (8 + TI)'(0)};
            r_rem   <= '0;
            r_cnt   <= 6'(DB - 1);
            r_fzero <= (r_half_life == '0) || (n_elapsed[31:24] != '0);
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 6'd1;
            if (!n_trial[HB]) begin
                r_rem <= n_trial[HB-1:0];
                r_dq  <= {r_dq[DB-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh[HB-1:0];
                r_dq  <= {r_dq[DB-2:0], 1'b0};
            end
        end
        if (i_cmd.fact) begin
            r_f   <= (r_fzero || n_fbig) ? '0 : hlda_pkg::EXP_TAB[r_dq[TI-1:0]] >> r_dq[TI+4:TI];
            r_neg <= n_opnd[32];
            r_mag <= n_opnd[32] ? 33'(-n_opnd) : 33'(n_opnd);
        end
        if (i_cmd.mul_lo) begin
            r_plo <= r_mag * r_f[15:0];
        end
        if (i_cmd.mul_hi) begin
            r_phi <= r_mag * r_f[FB-1:16];
        end
        if (i_cmd.round) begin
            r_prod <= r_neg ? -$signed(n_r) : $signed(n_r);
        end
        if (i_cmd.apply) begin
            r_proj <= (r_act == hlda_pkg::ACT_PROJECT && r_has) ? r_prod[31:0] : '0;
        end
        if (i_cmd.norm_load) begin
            r_va     <= r_avg[30:0];
            r_vt     <= n_thr;
            r_pa     <= 5'd30;
            r_pt     <= 5'd30;
            r_tvalid <= (r_half_life != '0) && (r_avg > $signed({1'b0, n_thr}));
        end
        if (i_cmd.norm_step) begin
            if (!r_va[30] && r_pa != 5'd0) begin
                r_va <= {r_va[29:0], 1'b0};
                r_pa <= r_pa - 5'd1;
            end
            if (!r_vt[30] && r_pt != 5'd0) begin
                r_vt <= {r_vt[29:0], 1'b0};
                r_pt <= r_pt - 5'd1;
            end
        end
        if (i_cmd.log_calc) begin
            r_d <= n_la - n_lt;
        end
        if (i_cmd.tmul) begin
            r_t <= r_tvalid ? n_tprod[44:16] : '0;
        end
        if (i_cmd.out_load) begin
            r_out_cur  <= r_avg;
            r_out_proj <= r_proj;
            r_out_tv   <= r_tvalid;
            r_out_t    <= {3'd0, r_t};
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_current_value        = r_out_cur;
    assign o_projected_value      = r_out_proj;
    assign o_threshold_time_valid = r_out_tv;
    assign o_threshold_time       = r_out_t;

endmodule

>>> rtl/core/hlda_ctrl.sv
// Controller: sequences one request through the datapath steps.
`timescale 1ns / 1ps

module hlda_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  hlda_pkg::t_sts  i_sts,
    output hlda_pkg::t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DINIT, S_DIV, S_FACT, S_MULLO, S_MULHI, S_ROUND,
        S_APPLY, S_NLOAD, S_NORM, S_LOG, S_TMUL, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_FACT;
            end
            S_FACT: begin
                o_cmd.fact = 1'b1;
                n_state = S_MULLO;
            end
            S_MULLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_NLOAD;
            end
            S_NLOAD: begin
                o_cmd.norm_load = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (i_sts.norm_done) n_state = S_LOG;
            end
            S_LOG: begin
                o_cmd.log_calc = 1'b1;
                n_state = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.tmul = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free) else $error("result loaded while busy");
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready) else $error("second request taken");
    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_last) |=> r_state == S_DIV)
        else $error("divider left early");
    a_apply_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> !o_cmd.apply) else $error("state updated twice");

endmodule

>>> rtl/core/half_life_decay_average_top.sv
// Top level of the half-life decay average.
`timescale 1ns / 1ps

// One request is processed at a time: a restoring divider forms the
// decay exponent, a split 33x16 multiplier applies the factor in two
// passes, and a shift normalizer finds the leading one of the value and
// of the threshold before the log tables are read. A finished result
// waits in the output register while the next request is taken.
module half_life_decay_average_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // sample[31:0], timestamp[63:32]
    input  logic [1:0]   s_axis_tuser,  // action[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // current_value[31:0], projected_value[63:32], threshold_time_valid[64],
    // threshold_time[96:65], zero fill [103:97]
    output logic [103:0] m_axis_tdata
);
    hlda_pkg::t_cmd w_cmd;
    hlda_pkg::t_sts w_sts;
    logic [31:0]    w_cur;
    logic [31:0]    w_proj;
    logic           w_tv;
    logic [31:0]    w_t;

    hlda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hlda_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_sts                  (w_sts),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_action               (s_axis_tuser),
        .i_sample               (s_axis_tdata[31:0]),
        .i_timestamp            (s_axis_tdata[63:32]),
        .i_out_ready            (m_axis_tready),
        .o_out_valid            (m_axis_tvalid),
        .o_current_value        (w_cur),
        .o_projected_value      (w_proj),
        .o_threshold_time_valid (w_tv),
        .o_threshold_time       (w_t)
    );

    assign m_axis_tdata = {7'd0, w_t, w_tv, w_proj, w_cur};

endmodule

>>> verif/tb_half_life_decay_average_top.sv
// Self-checking testbench for the half-life decay average: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_half_life_decay_average_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_SET  = 140;

    localparam int TABLE_INDEX_BITS = hlda_pkg::TABLE_INDEX_BITS;
    localparam int TAB_SIZE         = hlda_pkg::TAB_SIZE;
    localparam int FQ               = hlda_pkg::FQ;
    localparam int LOG_FRAC         = hlda_pkg::LOG_FRAC;

    typedef hlda_pkg::t_action    t_action;
    typedef hlda_pkg::t_reg_index t_reg_index;

    localparam t_action    ACT_UPDATE    = hlda_pkg::ACT_UPDATE;
    localparam t_action    ACT_PROJECT   = hlda_pkg::ACT_PROJECT;
    localparam t_action    ACT_RESET     = hlda_pkg::ACT_RESET;
    localparam t_action    ACT_NONE      = hlda_pkg::ACT_NONE;
    localparam t_reg_index REG_HALF_LIFE = hlda_pkg::REG_HALF_LIFE;
    localparam t_reg_index REG_THRESHOLD = hlda_pkg::REG_THRESHOLD;

    typedef struct packed {
        logic [31:0] cur;
        logic [31:0] proj;
        logic        tvalid;
        logic [31:0] ttime;
    } t_decay_result;

    typedef struct packed {
        logic          is_cfg;
        t_reg_index    idx;
        logic [30:0]   wdata;
        t_action       act;
        logic [31:0]   sample;
        logic [31:0]   ts;
        logic          typed;
        t_decay_result want;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = 1'b0;
    logic [30:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;

    half_life_decay_average_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    logic [63:0]   pow_tab [TAB_SIZE];
    logic [63:0]   lg_tab [TAB_SIZE];
    logic [23:0]   hl_reg = '0;
    logic [30:0]   thr_reg = hlda_pkg::THR_RESET;
    longint        avg = 0;
    logic [31:0]   last_ts = '0;
    logic          avg_valid = 1'b0;
    t_decay_result pending_q[$];
    int            errors = 0;
    int            idle_mode = 0;
    logic          hold_req = 1'b0;
    int            hold_left = 0;
    int            quiet_cycles = 0;
    logic [31:0]   cur_ts = '0;

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic void build_decay_tables();
        logic [63:0] roots [TABLE_INDEX_BITS];
        logic [63:0] e;
        logic [63:0] y;
        logic [63:0] r;
        roots[TABLE_INDEX_BITS-1] = floor_sqrt(64'd1 << (2 * FQ - 1));
        for (int j = TABLE_INDEX_BITS - 1; j > 0; j--) roots[j-1] = floor_sqrt(roots[j] << FQ);
        for (int i = 0; i < TAB_SIZE; i++) begin
            e = 64'd1 << FQ;
            for (int j = 0; j < TABLE_INDEX_BITS; j++) begin
                if (i[j]) e = (e * roots[j] + (64'd1 << (FQ - 1))) >> FQ;
            end
            pow_tab[i] = e;
            y = (64'd1 << FQ) + (64'(i) << (FQ - TABLE_INDEX_BITS));
            r = '0;
            for (int k = 0; k < LOG_FRAC; k++) begin
                y = (y * y) >> FQ;
                r = r << 1;
                if (y >= (64'd1 << (FQ + 1))) begin
                    r = r | 64'd1;
                    y = y >> 1;
                end
            end
            lg_tab[i] = r;
        end
    endfunction

    function automatic logic [63:0] factor_at(logic [31:0] ts);
        logic [63:0] el;
        logic [63:0] xq;
        logic [63:0] n;
        if (hl_reg == 0) return '0;
        el = (ts > last_ts) ? 64'(ts - last_ts) : 64'd0;
        if (el >= (64'd1 << 24)) return '0;
        xq = (el << (8 + TABLE_INDEX_BITS)) / 64'(hl_reg);
        n = xq >> TABLE_INDEX_BITS;
        if (n >= FQ + 1) return '0;
        return pow_tab[xq[TABLE_INDEX_BITS-1:0]] >> n;
    endfunction

    function automatic longint scale_q30(longint a, logic [63:0] f);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (a < 0) ? 64'(-a) : 64'(a);
        r = (mag * f + (64'd1 << (FQ - 1))) >> FQ;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] log2_q16(logic [63:0] v);
        int p;
        logic [63:0] m;
        p = 0;
        for (int i = 0; i < 64; i++) if (v[i]) p = i;
        if (p >= TABLE_INDEX_BITS) m = (v >> (p - TABLE_INDEX_BITS)) & (TAB_SIZE - 1);
        else m = (v << (TABLE_INDEX_BITS - p)) & (TAB_SIZE - 1);
        return (64'(p) << LOG_FRAC) + lg_tab[m];
    endfunction

    function automatic t_decay_result decay_predict(t_action act, logic [31:0] smp,
                                                    logic [31:0] ts);
        longint        s;
        longint        proj;
        logic [63:0]   thr;
        logic [63:0]   d;
        logic [63:0]   t;
        t_decay_result r;
        s = longint'(signed'(smp));
        proj = 0;
        case (act)
            ACT_UPDATE: begin
                if (!avg_valid) avg = s;
                else avg = s + scale_q30(avg - s, factor_at(ts));
                last_ts = ts;
                avg_valid = 1'b1;
            end
            ACT_PROJECT: begin
                if (avg_valid) proj = scale_q30(avg, factor_at(ts));
            end
            ACT_RESET: begin
                avg = 0;
                last_ts = '0;
                avg_valid = 1'b0;
            end
            default: ;
        endcase
        thr = (thr_reg == 0) ? 64'd1 : 64'(thr_reg);
        r.cur = 32'(avg);
        r.proj = 32'(proj);
        r.tvalid = 1'b0;
        r.ttime = '0;
        if (hl_reg != 0 && avg > longint'(thr)) begin
            d = log2_q16(64'(avg)) - log2_q16(thr);
            t = (64'(hl_reg) * d) >> LOG_FRAC;
            r.tvalid = 1'b1;
            r.ttime = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        end
        return r;
    endfunction

    task automatic write_reg(t_reg_index idx, logic [30:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_HALF_LIFE) hl_reg = value[23:0];
        else thr_reg = value;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sends one request and records what it should produce once it is taken.
    task automatic send_request(t_action act, logic [31:0] smp, logic [31:0] ts,
                                logic typed, t_decay_result want);
        int gap;
        t_decay_result r;
        gap = 0;
        if ((idle_mode == 1 || idle_mode == 3) && $urandom_range(0, 99) < 47)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ts, smp};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        r = decay_predict(act, smp, ts);
        pending_q.push_back(typed ? want : r);
    endtask

    always @(posedge i_clk) begin
        t_decay_result w;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                w = pending_q.pop_front();
                if (m_axis_tdata[31:0] !== w.cur) begin
                    $error("current_value: expected %h, got %h", w.cur, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== w.proj) begin
                    $error("projected_value: expected %h, got %h", w.proj,
                           m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[64] !== w.tvalid) begin
                    $error("threshold_time_valid: expected %b, got %b", w.tvalid,
                           m_axis_tdata[64]);
                    errors++;
                end
                if (m_axis_tdata[96:65] !== w.ttime) begin
                    $error("threshold_time: expected %h, got %h", w.ttime,
                           m_axis_tdata[96:65]);
                    errors++;
                end
            end
        end
        if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_req = 1'b0;
            m_axis_tready <= 1'b0;
        end else if (idle_mode == 2 || idle_mode == 3) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 47);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    localparam t_decay_result NO_RESULT = '0;
    localparam int N_ROWS = 22;
    t_stim_row rows [N_ROWS] = '{
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_PROJECT, 32'h0, 32'd5, 1'b1, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'h7FFF_FFFF, 32'd10, 1'b1,
          '{32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0}},
        '{1'b1, REG_HALF_LIFE, 31'd256, ACT_NONE, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'h8000_0000, 32'd11, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'h0003_0000, 32'd5, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_PROJECT, 32'h0, 32'd20, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_PROJECT, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_NONE, 32'hFFFF_FFFF, 32'd7, 1'b0, NO_RESULT},
        '{1'b1, REG_THRESHOLD, 31'd1, ACT_NONE, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'h7FFF_FFFF, 32'd100, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_PROJECT, 32'h0, 32'd100, 1'b0, NO_RESULT},
        '{1'b1, REG_THRESHOLD, 31'h7FFF_FFFF, ACT_NONE, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_PROJECT, 32'h0, 32'd101, 1'b0, NO_RESULT},
        '{1'b1, REG_HALF_LIFE, 31'hFF_FFFF, ACT_NONE, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'h4000_0000, 32'h0100_0064, 1'b0,
          NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{1'b1, REG_THRESHOLD, 31'd0, ACT_NONE, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0,
          NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_RESET, 32'h1234_5678, 32'd9, 1'b1, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_UPDATE, 32'hFFFF_0000, 32'd3, 1'b0, NO_RESULT},
        '{1'b1, REG_HALF_LIFE, 31'd0, ACT_NONE, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, REG_HALF_LIFE, 31'd0, ACT_PROJECT, 32'h0, 32'd4, 1'b0, NO_RESULT}
    };

    logic [23:0] set_hl [8] = '{24'd256, 24'd1, 24'hFF_FFFF, 24'd0, 24'd2560, 24'd37,
                                24'd65536, 24'd1000};
    logic [30:0] set_thr [8] = '{31'd65536, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'h10_0000,
                                 31'd300, 31'd3_276_800, 31'd65536};

    initial begin
        t_action     act;
        logic [31:0] smp;
        logic [31:0] ts;
        logic [63:0] span;
        int          pick;
        build_decay_tables();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain();
                write_reg(rows[i].idx, rows[i].wdata);
            end else begin
                send_request(rows[i].act, rows[i].sample, rows[i].ts, rows[i].typed,
                             rows[i].want);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_reg(REG_HALF_LIFE, 31'(set_hl[ph]));
            write_reg(REG_THRESHOLD, (ph == 7) ? 31'($urandom) : set_thr[ph]);
            idle_mode = ph % 4;
            span = 64'(hl_reg >> 8) + 1;
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (ph == 0 && n == 40) hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                act = (pick < 60) ? ACT_UPDATE : (pick < 87) ? ACT_PROJECT :
                      (pick < 96) ? ACT_RESET : ACT_NONE;
                smp = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 99) < 50) smp = $urandom;
                else if ($urandom_range(0, 99) < 25) smp = -smp;
                pick = $urandom_range(0, 99);
                if (pick < 70) ts = cur_ts + 32'($urandom_range(0, 32'(span * 8)));
                else if (pick < 78) ts = cur_ts;
                else if (pick < 88) ts = cur_ts - 32'($urandom_range(1, 1000));
                else if (pick < 95) ts = $urandom;
                else ts = cur_ts + 32'h0100_0000 + 32'($urandom_range(0, 3));
                if (act == ACT_UPDATE) cur_ts = ts;
                send_request(act, smp, ts, 1'b0, NO_RESULT);
            end
        end

        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> half_life_decay_average_top.f
rtl/core/hlda_pkg.sv
rtl/core/hlda_dp.sv
rtl/core/hlda_ctrl.sv
rtl/core/half_life_decay_average_top.sv
verif/tb_half_life_decay_average_top.sv
